/* hdl/hrp_pkg.sv */
// shared types and constants of the http response header parser
`default_nettype none

package hrp_pkg;

    // longest head in bytes; byte positions run from 0 to this value
    localparam int unsigned MAX_LEN = 4096;
    localparam int unsigned POS_W   = $clog2(MAX_LEN + 1);
    localparam int unsigned OFS_W   = 12;
    localparam int unsigned CODE_W  = 10;

    // result queue depth and pointer width
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

    // characters of the status line and header grammar
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // result kinds
    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_OK     = 2'd2,
        KIND_ERR    = 2'd3
    } t_kind;

    // parse phases, one-hot
    typedef enum logic [19:0] {
        PH_H         = 20'h00001,
        PH_T1        = 20'h00002,
        PH_T2        = 20'h00004,
        PH_P         = 20'h00008,
        PH_SLASH     = 20'h00010,
        PH_MAJOR     = 20'h00020,
        PH_DOT       = 20'h00040,
        PH_MINOR     = 20'h00080,
        PH_SP1       = 20'h00100,
        PH_D1        = 20'h00200,
        PH_D2        = 20'h00400,
        PH_D3        = 20'h00800,
        PH_SP2       = 20'h01000,
        PH_REASON    = 20'h02000,
        PH_REASON_LF = 20'h04000,
        PH_KEY       = 20'h08000,
        PH_COLON     = 20'h10000,
        PH_VALUE     = 20'h20000,
        PH_VSPACE    = 20'h40000,
        PH_NEWLINE   = 20'h80000
    } t_phase;

    // one input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_req_item;

    // one result
    typedef struct packed {
        t_kind             kind;
        logic [CODE_W-1:0] resp_code;
        logic [OFS_W-1:0]  key_offset;
        logic [OFS_W-1:0]  key_length;
        logic [OFS_W-1:0]  value_offset;
        logic [OFS_W-1:0]  value_length;
        logic              last_of_run;
    } t_res_item;

    // results caused by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        t_res_item  res0;
        t_res_item  res1;
    } t_step_out;

endpackage

`default_nettype wire

/* hdl/http_response_header_parser_unit.sv */
// top level of the http response header parser: input register, parser, result queue
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+---------------------------------
//  request  | i_req_valid  | o_req_ready  | i_req  (data_byte, last_byte)
//  result   | o_res_valid  | i_res_ready  | o_res  (kind .. last_of_run)
//
// one request per cycle while the result queue has room; a byte is parsed from the
// input register, and its results reach o_res through the result queue
// a byte with two results fills two result queue slots; the queue drains
// one result per cycle while i_res_ready is high, so such bytes take two pops
// a stalled result side holds the input register once the queue has fewer
// than two free slots; synchronous active-low reset clears all control state

`default_nettype none

module http_response_header_parser_unit (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_req_valid,
    output                     logic o_req_ready,
    input  hrp_pkg::t_req_item       i_req,
    output                     logic o_res_valid,
    input  wire                logic i_res_ready,
    output hrp_pkg::t_res_item       o_res
);
    import hrp_pkg::*;

    logic                 r_in_valid;
    t_req_item            r_in;
    logic                 l_go;
    logic                 l_take;
    logic                 l_pop;
    t_step_out            l_step;

    t_res_item            r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0]     r_wr;
    logic [OQ_AW-1:0]     r_rd;
    logic [OQ_AW:0]       r_cnt;
    logic [OQ_AW:0]       n_cnt;

    // handshake control
    always_comb begin
        l_go        = r_in_valid && (r_cnt <= (OQ_AW+1)'(OQ_DEPTH - 2));
        o_req_ready = !r_in_valid || l_go;
        l_take      = i_req_valid && o_req_ready;
        o_res_valid = (r_cnt != '0);
        l_pop       = o_res_valid && i_res_ready;
        o_res       = r_oq[r_rd];
        n_cnt       = r_cnt + (OQ_AW+1)'(l_step.count) - (OQ_AW+1)'(l_pop);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_in_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_take) begin
            r_in <= i_req;
        end
    end

    // parser
    hrp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (l_go),
        .i_item  (r_in),
        .o_out   (l_step)
    );

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (l_go && (l_step.count != 2'd0)) begin
            r_oq[r_wr] <= l_step.res0;
        end
        if (l_go && (l_step.count == 2'd2)) begin
            r_oq[r_wr + OQ_AW'(1)] <= l_step.res1;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (l_go) begin
                r_wr <= r_wr + OQ_AW'(l_step.count);
            end
            if (l_pop) begin
                r_rd <= r_rd + OQ_AW'(1);
            end
            r_cnt <= l_go ? n_cnt : (r_cnt - (OQ_AW+1)'(l_pop));
        end
    end

`ifndef SYNTHESIS
    // queue never holds more than its depth
    a_oq_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("result queue overflow");

    // a byte with two results leads with a status or header report
    a_pair_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (l_go && (l_step.count == 2'd2)) |->
        ((l_step.res0.kind == KIND_STATUS) || (l_step.res0.kind == KIND_HEADER)))
        else $error("two results without a leading report");

    // a finish result is always the final result of its byte
    a_finish_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && ((o_res.kind == KIND_OK) || (o_res.kind == KIND_ERR))) |->
        o_res.last_of_run)
        else $error("finish result not marked last");

    // a parsed byte never finds the queue without room
    a_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        l_go |=> (r_cnt != '0) || ($past(l_step.count) == 2'd0) || $past(l_pop))
        else $error("results of a parsed byte went missing");
`endif

endmodule

`default_nettype wire

/* hdl/hrp_step.sv */
// parse state and the per-byte update with its results
`default_nettype none

module hrp_step (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_go,
    input  hrp_pkg::t_req_item       i_item,
    output hrp_pkg::t_step_out       o_out
);
    import hrp_pkg::*;

    t_phase              r_phase,  n_phase;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic [CODE_W-1:0]   r_acc,    n_acc;
    logic [POS_W-1:0]    r_kstart, n_kstart;
    logic [OFS_W-1:0]    r_kstop,  n_kstop;
    logic [OFS_W-1:0]    r_vstart, n_vstart;
    logic [OFS_W-1:0]    r_vstop,  n_vstop;
    logic                r_fin,    n_fin;

    t_res_item           l_a;
    t_res_item           l_b;
    logic                l_a_valid;
    logic                l_b_valid;
    logic                l_pat;
    logic                l_good;
    t_phase              l_nxt;
    logic [7:0]          l_c;
    logic                l_digit;
    logic                l_blank;
    logic                l_space;
    logic [CODE_W+3:0]   l_acc_wide;
    logic [POS_W-1:0]    l_pos_inc;

    // character classes of the current byte
    always_comb begin
        l_c     = i_item.data_byte;
        l_digit = (l_c >= CH_ZERO) && (l_c <= CH_NINE);
        l_blank = (l_c == CH_SPACE) || (l_c == CH_TAB);
        l_space = (l_c == CH_SPACE) || ((l_c >= CH_TAB) && (l_c <= CH_CR));
        l_pos_inc  = r_pos + POS_W'(1);
        l_acc_wide = (CODE_W+4)'(r_acc) * (CODE_W+4)'(10) + (CODE_W+4)'(l_c[3:0]);
    end

    // next state and results for one byte
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_kstart  = r_kstart;
        n_kstop   = r_kstop;
        n_vstart  = r_vstart;
        n_vstop   = r_vstop;
        n_fin     = r_fin;
        l_a       = '0;
        l_b       = '0;
        l_a_valid = 1'b0;
        l_b_valid = 1'b0;
        l_pat     = 1'b0;
        l_good    = 1'b0;
        l_nxt     = r_phase;

        if (!r_fin) begin
            if (r_pos >= POS_W'(MAX_LEN)) begin
                // length limit reached
                l_a_valid = 1'b1;
                l_a.kind  = KIND_ERR;
                n_fin     = 1'b1;
            end else begin
                n_pos = l_pos_inc;
                case (r_phase)
                    PH_H: begin
                        l_pat = 1'b1; l_good = (l_c == CH_H); l_nxt = PH_T1;
                    end
                    PH_T1: begin
                        l_pat = 1'b1; l_good = (l_c == CH_T); l_nxt = PH_T2;
                    end
                    PH_T2: begin
                        l_pat = 1'b1; l_good = (l_c == CH_T); l_nxt = PH_P;
                    end
                    PH_P: begin
                        l_pat = 1'b1; l_good = (l_c == CH_P); l_nxt = PH_SLASH;
                    end
                    PH_SLASH: begin
                        l_pat = 1'b1; l_good = (l_c == CH_SLASH); l_nxt = PH_MAJOR;
                    end
                    PH_MAJOR: begin
                        l_pat = 1'b1; l_good = l_digit; l_nxt = PH_DOT;
                    end
                    PH_DOT: begin
                        l_pat = 1'b1; l_good = (l_c == CH_DOT); l_nxt = PH_MINOR;
                    end
                    PH_MINOR: begin
                        l_pat = 1'b1; l_good = l_digit; l_nxt = PH_SP1;
                    end
                    PH_SP1: begin
                        l_pat = 1'b1; l_good = (l_c == CH_SPACE); l_nxt = PH_D1;
                    end
                    PH_D1: begin
                        l_pat = 1'b1; l_good = l_digit; l_nxt = PH_D2;
                    end
                    PH_D2: begin
                        l_pat = 1'b1; l_good = l_digit; l_nxt = PH_D3;
                    end
                    PH_D3: begin
                        l_pat = 1'b1; l_good = l_digit; l_nxt = PH_SP2;
                    end
                    PH_SP2: begin
                        l_pat = 1'b1; l_good = (l_c == CH_SPACE); l_nxt = PH_REASON;
                    end
                    PH_REASON: begin
                        if (l_c == CH_CR) begin
                            n_kstop = OFS_W'(r_pos);
                            n_phase = PH_REASON_LF;
                        end
                    end
                    PH_REASON_LF: begin
                        if (l_c != CH_LF) begin
                            l_a_valid = 1'b1; l_a.kind = KIND_ERR; n_fin = 1'b1;
                        end else begin
                            l_a_valid     = 1'b1;
                            l_a.kind      = KIND_STATUS;
                            l_a.resp_code   = r_acc;
                            l_a.key_offset  = OFS_W'(r_kstart);
                            l_a.key_length  = r_kstop - OFS_W'(r_kstart);
                            n_kstart      = l_pos_inc;
                            n_phase       = PH_KEY;
                        end
                    end
                    PH_KEY: begin
                        if (l_c == CH_COLON) begin
                            if (r_kstart == r_pos) begin
                                l_a_valid = 1'b1; l_a.kind = KIND_ERR; n_fin = 1'b1;
                            end else begin
                                n_kstop = OFS_W'(r_pos);
                                n_phase = PH_COLON;
                            end
                        end else if ((l_c == CH_CR) && (r_kstart == r_pos)) begin
                            // blank line ends the head
                            l_a_valid = 1'b1; l_a.kind = KIND_OK; n_fin = 1'b1;
                        end else if (l_space) begin
                            l_a_valid = 1'b1; l_a.kind = KIND_ERR; n_fin = 1'b1;
                        end
                    end
                    PH_COLON: begin
                        if (!l_blank) begin
                            if (l_space) begin
                                l_a_valid = 1'b1; l_a.kind = KIND_ERR; n_fin = 1'b1;
                            end else begin
                                n_vstart = OFS_W'(r_pos);
                                n_phase  = PH_VALUE;
                            end
                        end
                    end
                    PH_VALUE: begin
                        if (l_c == CH_CR) begin
                            n_vstop = OFS_W'(r_pos);
                            n_phase = PH_NEWLINE;
                        end else if (l_blank) begin
                            n_vstop = OFS_W'(r_pos);
                            n_phase = PH_VSPACE;
                        end
                    end
                    PH_VSPACE: begin
                        if (l_c == CH_CR) begin
                            n_phase = PH_NEWLINE;
                        end else if (!l_blank) begin
                            n_phase = PH_VALUE;
                        end
                    end
                    PH_NEWLINE: begin
                        if (l_c != CH_LF) begin
                            l_a_valid = 1'b1; l_a.kind = KIND_ERR; n_fin = 1'b1;
                        end else begin
                            l_a_valid        = 1'b1;
                            l_a.kind         = KIND_HEADER;
                            l_a.key_offset   = OFS_W'(r_kstart);
                            l_a.key_length   = r_kstop - OFS_W'(r_kstart);
                            l_a.value_offset = r_vstart;
                            l_a.value_length = r_vstop - r_vstart;
                            n_kstart         = l_pos_inc;
                            n_phase          = PH_KEY;
                        end
                    end
                    default: begin
                        l_a_valid = 1'b1; l_a.kind = KIND_ERR; n_fin = 1'b1;
                    end
                endcase

                // status line pattern check and digit accumulation
                if (l_pat) begin
                    if (!l_good) begin
                        l_a_valid = 1'b1; l_a.kind = KIND_ERR; n_fin = 1'b1;
                    end else begin
                        n_phase = l_nxt;
                        if ((r_phase == PH_D1) || (r_phase == PH_D2) || (r_phase == PH_D3)) begin
                            n_acc = CODE_W'(l_acc_wide);
                        end
                        if (r_phase == PH_SP2) begin
                            n_kstart = l_pos_inc;
                        end
                    end
                end
            end

            // end of buffer: fine in the header section, an error before it
            if (!n_fin && i_item.last_byte) begin
                l_b_valid = 1'b1;
                l_b.kind  = ((n_phase == PH_KEY) || (n_phase == PH_COLON) ||
                             (n_phase == PH_VALUE) || (n_phase == PH_VSPACE) ||
                             (n_phase == PH_NEWLINE)) ? KIND_OK : KIND_ERR;
                n_fin     = 1'b1;
            end
        end

        // every last byte starts a new message
        if (i_item.last_byte) begin
            n_phase  = PH_H;
            n_pos    = '0;
            n_acc    = '0;
            n_kstart = '0;
            n_kstop  = '0;
            n_vstart = '0;
            n_vstop  = '0;
            n_fin    = 1'b0;
        end

        // order the results and mark the final one
        l_a.last_of_run = !l_b_valid;
        l_b.last_of_run = 1'b1;
        o_out.count = {1'b0, l_a_valid} + {1'b0, l_b_valid};
        o_out.res0  = l_a_valid ? l_a : l_b;
        o_out.res1  = l_b;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_H;
            r_pos    <= '0;
            r_acc    <= '0;
            r_kstart <= '0;
            r_kstop  <= '0;
            r_vstart <= '0;
            r_vstop  <= '0;
            r_fin    <= 1'b0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_kstart <= n_kstart;
            r_kstop  <= n_kstop;
            r_vstart <= n_vstart;
            r_vstop  <= n_vstop;
            r_fin    <= n_fin;
        end
    end

endmodule

`default_nettype wire
